### sv/sha_pkg.sv
package sha_pkg;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // word 0 in the low 32 bits
  localparam logic [7:0][31:0] SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] SHA_PAD_BYTE = 8'h80;
  localparam logic [5:0] SHA_LEN_POS  = 6'd56;

  typedef struct packed {
    logic       shift;  // shift one message byte into the block
    logic       step;   // advance the schedule by one word
    logic [7:0] data;
  } sha_sched_ctl_t;

  typedef struct packed {
    logic load;  // working vars <= hash words
    logic step;  // one compression round
    logic fin;   // hash words += working vars
    logic init;  // hash words <= initial values
  } sha_rnd_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    return (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return ror32(x, 5'd2) ^ ror32(x, 5'd13) ^ ror32(x, 5'd22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return ror32(x, 5'd6) ^ ror32(x, 5'd11) ^ ror32(x, 5'd25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return ror32(x, 5'd7) ^ ror32(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return ror32(x, 5'd17) ^ ror32(x, 5'd19) ^ (x >> 10);
  endfunction

endpackage

### sv/sha_msg_sched.sv
module sha_msg_sched (
  input  logic                    clk,
  input  sha_pkg::sha_sched_ctl_t ctl,
  output logic [31:0]             w
);
  import sha_pkg::*;

  // sw_r[0] is the oldest word; it carries W[r] during round r
  logic [31:0] sw_r   [16];
  logic [31:0] sw_nxt [16];
  logic [31:0] w_new;

  assign w     = sw_r[0];
  assign w_new = sw_r[0] + small_s0(sw_r[1]) + sw_r[9] + small_s1(sw_r[14]);

  always_comb begin
    for (int i = 0; i < 16; i++) sw_nxt[i] = sw_r[i];
    if (ctl.shift) begin
      // whole block moves up by one byte, big-endian within each word
      for (int i = 0; i < 15; i++) sw_nxt[i] = {sw_r[i][23:0], sw_r[i+1][31:24]};
      sw_nxt[15] = {sw_r[15][23:0], ctl.data};
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) sw_nxt[i] = sw_r[i+1];
      sw_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) sw_r[i] <= sw_nxt[i];
  end

endmodule

### sv/sha_round.sv
module sha_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha_pkg::sha_rnd_ctl_t ctl,
  input  logic [5:0]            rnd,
  input  logic [31:0]           w,
  output logic [7:0][31:0]      hash
);
  import sha_pkg::*;

  // index 0..7 = a..h
  logic [7:0][31:0] wv_r, wv_nxt;
  logic [7:0][31:0] hash_r, hash_nxt;
  logic [31:0]      t1, t2, ch, maj;

  assign hash = hash_r;

  assign ch  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1  = wv_r[7] + big_s1(wv_r[4]) + ch + SHA_K[rnd] + w;
  assign t2  = big_s0(wv_r[0]) + maj;

  always_comb begin
    wv_nxt   = wv_r;
    hash_nxt = hash_r;
    if (ctl.load) begin
      wv_nxt = hash_r;
    end else if (ctl.step) begin
      wv_nxt[0] = t1 + t2;
      wv_nxt[1] = wv_r[0];
      wv_nxt[2] = wv_r[1];
      wv_nxt[3] = wv_r[2];
      wv_nxt[4] = wv_r[3] + t1;
      wv_nxt[5] = wv_r[4];
      wv_nxt[6] = wv_r[5];
      wv_nxt[7] = wv_r[6];
    end
    if (ctl.fin) begin
      for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + wv_r[i];
    end else if (ctl.init) begin
      hash_nxt = SHA_IV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= SHA_IV;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r <= wv_nxt;
  end

endmodule

### sv/sha256_hash_engine_top.sv
// Channel | Dir | tdata                 | tuser        | tlast
// in_     | in  | [7:0] msg_byte        | [0] has_byte | msg_end
// out_    | out | [31:0] digest_word    | -            | digest_last
//
// Byte items are shifted into the block. A full 64-byte block is then compressed by
// one round unit, round by round in S_ROUND, and folded into the hash in S_FIN.
// End of message: S_PAD fills the block, then rounds and fold run for the pad block;
// with 56 or more bytes held a second pad block is filled, rounded and folded too.
// Then S_DONE moves the digest to the output buffer.
// Input is ready only in idle. The 8-word output buffer drains on its own; a
// digest waits for it to empty. Reset is synchronous, active low.
module sha256_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic [0:0]  in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast
);
  import sha_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FIN, S_DONE} state_t;
  typedef enum logic [1:0] {K_DATA, K_DATA_END, K_PAD1, K_LAST} blk_kind_t;

  state_t           state_r, state_nxt;
  blk_kind_t        kind_r, kind_nxt;
  logic [5:0]       fill_r, fill_nxt, fill_inc;
  logic [60:0]      len_r, len_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic             two_blk_r, two_blk_nxt;
  logic             pad_first_r, pad_first_nxt;
  logic [7:0][31:0] dig_r, dig_nxt;
  logic [3:0]       out_cnt_r, out_cnt_nxt;

  sha_sched_ctl_t   sch_ctl;
  sha_rnd_ctl_t     rnd_ctl;
  logic [31:0]      w;
  logic [7:0][31:0] hash;
  logic [63:0]      bit_len;
  logic [7:0]       len_byte;

  sha_msg_sched u_sched (
    .clk (clk),
    .ctl (sch_ctl),
    .w   (w)
  );

  sha_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rnd_ctl),
    .rnd   (rnd_r),
    .w     (w),
    .hash  (hash)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (out_cnt_r != 4'd0);
  assign out_tdata  = dig_r[0];
  assign out_tlast  = (out_cnt_r == 4'd1);

  assign fill_inc = fill_r + 6'd1;
  assign bit_len  = {len_r, 3'b000};
  // byte 56 holds the top length byte
  assign len_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    two_blk_nxt   = two_blk_r;
    pad_first_nxt = pad_first_r;
    dig_nxt       = dig_r;
    out_cnt_nxt   = out_cnt_r;
    sch_ctl       = '0;
    rnd_ctl       = '0;

    if (out_tvalid && out_tready) begin
      dig_nxt     = {32'd0, dig_r[7:1]};
      out_cnt_nxt = out_cnt_r - 4'd1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            sch_ctl.shift = 1'b1;
            sch_ctl.data  = in_tdata;
            fill_nxt      = fill_inc;
            len_nxt       = len_r + 61'd1;
          end
          if (in_tuser[0] && fill_r == 6'd63) begin
            state_nxt    = S_ROUND;
            kind_nxt     = in_tlast ? K_DATA_END : K_DATA;
            rnd_ctl.load = 1'b1;
            rnd_nxt      = 6'd0;
          end else if (in_tlast) begin
            state_nxt     = S_PAD;
            pad_first_nxt = 1'b1;
            two_blk_nxt   = in_tuser[0] ? (fill_inc >= SHA_LEN_POS) : (fill_r >= SHA_LEN_POS);
          end
        end
      end
      S_PAD: begin
        sch_ctl.shift = 1'b1;
        if (pad_first_r) begin
          sch_ctl.data = SHA_PAD_BYTE;
        end else if (!two_blk_r && fill_r >= SHA_LEN_POS) begin
          sch_ctl.data = len_byte;
        end else begin
          sch_ctl.data = 8'd0;
        end
        fill_nxt      = fill_inc;
        pad_first_nxt = 1'b0;
        if (fill_r == 6'd63) begin
          state_nxt    = S_ROUND;
          kind_nxt     = two_blk_r ? K_PAD1 : K_LAST;
          rnd_ctl.load = 1'b1;
          rnd_nxt      = 6'd0;
        end
      end
      S_ROUND: begin
        rnd_ctl.step = 1'b1;
        sch_ctl.step = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        rnd_ctl.fin = 1'b1;
        case (kind_r)
          K_DATA: state_nxt = S_IDLE;
          K_DATA_END: begin
            state_nxt     = S_PAD;
            pad_first_nxt = 1'b1;
            two_blk_nxt   = 1'b0;
          end
          K_PAD1: begin
            state_nxt     = S_PAD;
            pad_first_nxt = 1'b0;
            two_blk_nxt   = 1'b0;
          end
          K_LAST:  state_nxt = S_DONE;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DONE: begin
        if (out_cnt_r == 4'd0) begin
          dig_nxt      = hash;
          out_cnt_nxt  = 4'd8;
          rnd_ctl.init = 1'b1;
          len_nxt      = '0;
          fill_nxt     = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_DATA;
      fill_r      <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      two_blk_r   <= 1'b0;
      pad_first_r <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      rnd_r       <= rnd_nxt;
      two_blk_r   <= two_blk_nxt;
      pad_first_r <= pad_first_nxt;
      out_cnt_r   <= out_cnt_nxt;
    end
    dig_r <= dig_nxt;
  end

  a_round_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && rnd_r == 6'd63 |=> state_r == S_FIN)
    else $error("round count did not end in fold");

  a_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> fill_r == 6'd0)
    else $error("block fill not empty after compression");

  a_digest_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_cnt_r == 4'd0 |=> out_cnt_r == 4'd8 && state_r == S_IDLE)
    else $error("digest not loaded into output buffer");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> out_cnt_r == 4'd0)
    else $error("output buffer not empty after last word");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= 4'd8)
    else $error("output count out of range");

endmodule
